// ===== design/ptrs_pkg.sv =====
// shared types, codes and constants of the peer table roaming selector
package ptrs_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int MAG_W = 14;
	localparam int CNT_W = 4;

	localparam logic signed [7:0] SIG_MIN = -8'sd120;
	localparam logic signed [7:0] SIG_MAX = 8'sd20;
	localparam logic signed [7:0] WEAK_LINK = -8'sd75;
	localparam logic signed [7:0] NO_SIGNAL = -8'sd127;

	typedef enum logic [2:0] {
		CMD_SCAN_REPORT = 3'd0,
		CMD_SCAN_DONE   = 3'd1,
		CMD_CONNECT_OK  = 3'd2,
		CMD_CONNECT_BAD = 3'd3,
		CMD_DISCONNECT  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_ROAM    = 2'd1,
		ACT_CONNECT = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_SMOOTH  = 3'd0,
		REG_MARGIN  = 3'd1,
		REG_MAXFAIL = 3'd2,
		REG_BLOCK   = 3'd3,
		REG_AGE     = 3'd4,
		REG_HOLDOFF = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DECIDE,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic walk_step;
		logic div_start;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic need_div;
		logic div_done;
		logic out_busy;
	} ctrl_stat_t;

endpackage

// ===== design/ptrs_ctrl.sv =====
// sequencing state machine of the peer table roaming selector
module ptrs_ctrl import ptrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = stat.need_div ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_WALK:   ctl.walk_step = 1'b1;
			ST_DECIDE: ctl.div_start = stat.need_div;
			ST_DIV:    ;
			ST_FINISH: ctl.finish = !stat.out_busy;
			default:   ;
		endcase
	end

endmodule

// ===== design/ptrs_dp.sv =====
// peer table, registers, averaging divider and result register
module ptrs_dp import ptrs_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         ctl,
	output ctrl_stat_t        stat,
	input  logic [2:0]        cmd,
	input  logic [47:0]       peer_addr,
	input  logic [1:0]        peer_addr_kind,
	input  logic signed [7:0] signal_dbm,
	input  logic              service_seen,
	input  logic [31:0]       now_ticks,
	input  logic              link_idle,
	input  logic              data_pending,
	input  logic              link_signal_valid,
	input  logic signed [7:0] link_signal_dbm,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic [2:0]        slot,
	output logic [47:0]       chosen_addr,
	output logic [1:0]        chosen_addr_kind,
	output logic signed [7:0] best_dbm,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(ENTRIES - 1);

	// configuration
	logic [6:0]  smooth_q, margin_q;
	logic [7:0]  maxfail_q;
	logic [31:0] block_q, age_q, holdoff_q;

	// table
	logic [49:0]       e_addr_q [ENTRIES];
	logic signed [7:0] e_dbm_q [ENTRIES];
	logic [31:0]       e_seen_q [ENTRIES];
	logic [ENTRIES-1:0] e_valid_q;
	logic [7:0]        e_fail_q [ENTRIES];
	logic [31:0]       e_block_q [ENTRIES];

	// link state
	logic              link_up_q;
	logic [49:0]       link_peer_q;
	logic signed [7:0] link_dbm_q;
	logic              pend_valid_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [31:0]       last_roam_q;

	// captured word
	logic [2:0]        cmd_q;
	logic [49:0]       key_q;
	logic signed [7:0] sig_q;
	logic              svc_q;
	logic [31:0]       now_q;
	logic              idle_q, data_q, lsv_q;
	logic signed [7:0] lsig_q;

	// walk results
	logic [SLOT_W-1:0] idx_q;
	logic              match_found_q, free_found_q, best_found_q;
	logic [SLOT_W-1:0] match_idx_q, free_idx_q, weak_idx_q, best_idx_q;
	logic signed [7:0] weak_dbm_q, best_sig_q;

	// divider
	logic [MAG_W-1:0] mag_q, quo_q;
	logic [6:0]       rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] div_cnt_q;

	logic              out_valid_q;
	logic [1:0]        action_q;
	logic [2:0]        slot_q;
	logic [49:0]       addr_q;
	logic signed [7:0] best_q;

	// per-step combinational terms
	logic              cur_valid, cur_match, cur_aged, cur_blocked;
	logic [31:0]       cur_elapsed;
	logic              report_ok;
	logic [6:0]        div_f, div_fm1;
	logic signed [15:0] dbm_ext, fm1_ext, sig_ext, num;
	logic [15:0]       num_abs;
	logic [7:0]        rem_sh;
	logic              rem_ge;
	logic signed [7:0] new_dbm, link_dbm_eff;
	logic signed [9:0] roam_thr;
	logic [31:0]       roam_elapsed;
	logic              roam_ok;
	logic [SLOT_W-1:0] fill_idx;
	logic [7:0]        fail_next;

	assign cur_valid   = e_valid_q[idx_q];
	assign cur_match   = cur_valid && (e_addr_q[idx_q] == key_q);
	assign cur_elapsed = now_q - e_seen_q[idx_q];
	assign cur_aged    = cur_elapsed > age_q;
	assign cur_blocked = e_block_q[idx_q] > now_q;

	assign report_ok = svc_q && (sig_q >= SIG_MIN) && (sig_q <= SIG_MAX);

	assign div_f   = (smooth_q == 7'd0) ? 7'd1 : smooth_q;
	assign div_fm1 = div_f - 7'd1;
	assign dbm_ext = 16'(e_dbm_q[match_idx_q]);
	assign fm1_ext = signed'(16'(div_fm1));
	assign sig_ext = 16'(sig_q);
	assign num     = dbm_ext * fm1_ext + sig_ext;
	assign num_abs = num[15] ? 16'(-num) : 16'(num);

	assign rem_sh = {rem_q, mag_q[MAG_W-1]};
	assign rem_ge = rem_sh >= {1'b0, div_f};

	// truncation toward zero, same as signed integer division
	assign new_dbm      = neg_q ? -signed'(quo_q[7:0]) : signed'(quo_q[7:0]);
	assign link_dbm_eff = (key_q == link_peer_q) ? new_dbm : link_dbm_q;
	assign roam_thr     = 10'(link_dbm_eff) + signed'(10'(margin_q));
	assign roam_elapsed = now_q - last_roam_q;
	assign roam_ok = idle_q && link_up_q && (key_q != link_peer_q)
		&& (10'(new_dbm) > roam_thr) && (link_dbm_eff < WEAK_LINK)
		&& (roam_elapsed > holdoff_q);

	assign fill_idx  = free_found_q ? free_idx_q : weak_idx_q;
	assign fail_next = e_fail_q[pend_slot_q] + 8'd1;

	assign stat.walk_last = idx_q == LAST_IDX;
	assign stat.need_div  = (cmd_q == CMD_SCAN_REPORT) && report_ok && match_found_q;
	assign stat.div_done  = div_cnt_q == '0;
	assign stat.out_busy  = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= 7'd4;
			margin_q  <= 7'd10;
			maxfail_q <= 8'd3;
			block_q   <= 32'd30000;
			age_q     <= 32'd6000;
			holdoff_q <= 32'd8000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SMOOTH:  smooth_q  <= cfg_data[6:0];
				REG_MARGIN:  margin_q  <= cfg_data[6:0];
				REG_MAXFAIL: maxfail_q <= cfg_data[7:0];
				REG_BLOCK:   block_q   <= cfg_data;
				REG_AGE:     age_q     <= cfg_data;
				REG_HOLDOFF: holdoff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured word and walk bookkeeping
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			key_q  <= {peer_addr_kind, peer_addr};
			sig_q  <= signal_dbm;
			svc_q  <= service_seen;
			now_q  <= now_ticks;
			idle_q <= link_idle;
			data_q <= data_pending;
			lsv_q  <= link_signal_valid;
			lsig_q <= link_signal_dbm;
			idx_q  <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
			best_sig_q    <= NO_SIGNAL;
		end else if (ctl.walk_step) begin
			if (!stat.walk_last) idx_q <= idx_q + 1'b1;
			if (cur_match && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_q;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if ((idx_q == '0) || (e_dbm_q[idx_q] < weak_dbm_q)) begin
				weak_idx_q <= idx_q;
				weak_dbm_q <= e_dbm_q[idx_q];
			end
			if (cmd_q == CMD_SCAN_DONE && cur_valid && !cur_aged && !cur_blocked
				&& e_dbm_q[idx_q] > best_sig_q) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_q;
				best_sig_q   <= e_dbm_q[idx_q];
			end
		end
	end

	// restoring divider for the running average, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (ctl.div_start) begin
			div_cnt_q <= CNT_W'(MAG_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			mag_q <= num_abs[MAG_W-1:0];
			neg_q <= num[15];
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_cnt_q != '0) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			quo_q <= {quo_q[MAG_W-2:0], rem_ge};
			rem_q <= rem_ge ? 7'(rem_sh - {1'b0, div_f}) : rem_sh[6:0];
		end
	end

	// table payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.finish && cmd_q == CMD_SCAN_REPORT && report_ok) begin
			if (match_found_q) begin
				e_dbm_q[match_idx_q]  <= new_dbm;
				e_seen_q[match_idx_q] <= now_q;
			end else begin
				e_addr_q[fill_idx] <= key_q;
				e_dbm_q[fill_idx]  <= sig_q;
				e_seen_q[fill_idx] <= now_q;
			end
		end
	end

	// table control state and link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				e_fail_q[i]  <= 8'd0;
				e_block_q[i] <= 32'd0;
			end
			link_up_q    <= 1'b0;
			link_peer_q  <= '0;
			link_dbm_q   <= NO_SIGNAL;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			last_roam_q  <= 32'd0;
		end else if (ctl.walk_step) begin
			// stale entries drop out during the scan-complete walk
			if (cmd_q == CMD_SCAN_DONE && cur_valid && cur_aged) begin
				e_valid_q[idx_q] <= 1'b0;
				e_fail_q[idx_q]  <= 8'd0;
				e_block_q[idx_q] <= 32'd0;
			end
		end else if (ctl.finish) begin
			case (cmd_q)
				CMD_SCAN_REPORT: begin
					if (report_ok) begin
						if (match_found_q) begin
							link_dbm_q <= link_dbm_eff;
							if (roam_ok) last_roam_q <= now_q;
						end else begin
							e_valid_q[fill_idx] <= 1'b1;
							e_fail_q[fill_idx]  <= 8'd0;
							e_block_q[fill_idx] <= 32'd0;
						end
					end
				end
				CMD_SCAN_DONE: begin
					if (best_found_q && data_q && !link_up_q) begin
						link_dbm_q   <= best_sig_q;
						pend_valid_q <= 1'b1;
						pend_slot_q  <= best_idx_q;
					end else if (link_up_q && lsv_q) begin
						link_dbm_q <= lsig_q;
					end
				end
				CMD_CONNECT_OK: begin
					link_up_q    <= 1'b1;
					link_dbm_q   <= NO_SIGNAL;
					pend_valid_q <= 1'b0;
					link_peer_q  <= key_q;
					if (match_found_q) begin
						e_fail_q[match_idx_q]  <= 8'd0;
						e_block_q[match_idx_q] <= 32'd0;
					end
				end
				CMD_CONNECT_BAD: begin
					if (pend_valid_q) begin
						if (fail_next >= maxfail_q) begin
							e_block_q[pend_slot_q] <= now_q + block_q;
							e_fail_q[pend_slot_q]  <= 8'd0;
						end else begin
							e_fail_q[pend_slot_q] <= fail_next;
						end
					end
					pend_valid_q <= 1'b0;
					link_up_q    <= 1'b0;
				end
				CMD_DISCONNECT: begin
					link_up_q  <= 1'b0;
					link_dbm_q <= NO_SIGNAL;
				end
				default: ;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			action_q <= ACT_NONE;
			slot_q   <= 3'd0;
			addr_q   <= '0;
			best_q   <= NO_SIGNAL;
			if (cmd_q == CMD_SCAN_REPORT && report_ok && match_found_q && roam_ok) begin
				action_q <= ACT_ROAM;
				slot_q   <= 3'(match_idx_q);
				addr_q   <= key_q;
			end
			if (cmd_q == CMD_SCAN_DONE) begin
				best_q <= best_sig_q;
				if (best_found_q && data_q && !link_up_q) begin
					action_q <= ACT_CONNECT;
					slot_q   <= 3'(best_idx_q);
					addr_q   <= e_addr_q[best_idx_q];
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign action           = action_q;
	assign slot             = slot_q;
	assign chosen_addr      = addr_q[47:0];
	assign chosen_addr_kind = addr_q[49:48];
	assign best_dbm         = best_q;

endmodule

// ===== design/peer_table_roaming_selector.sv =====
// sequence: ENTRIES walk steps (one entry a cycle), a decide state, a divide for a scan
// report that refreshes a known peer, then a finish state that registers the result
// throughput: one word at a time, next word accepted in the cycle after the result
// is registered; the result register holds a word while the next one is taken
// reset: table emptied, failures and block times cleared, link down, registers
// at their defaults; no clearing pass needed
module peer_table_roaming_selector import ptrs_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [47:0]       peer_addr,
	input  logic [1:0]        peer_addr_kind,
	input  logic signed [7:0] signal_dbm,
	input  logic              service_seen,
	input  logic [31:0]       now_ticks,
	input  logic              link_idle,
	input  logic              data_pending,
	input  logic              link_signal_valid,
	input  logic signed [7:0] link_signal_dbm,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic [2:0]        slot,
	output logic [47:0]       chosen_addr,
	output logic [1:0]        chosen_addr_kind,
	output logic signed [7:0] best_dbm,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	ctrl_cmd_t  ctl;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	ptrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	ptrs_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.stat              (stat),
		.cmd               (cmd),
		.peer_addr         (peer_addr),
		.peer_addr_kind    (peer_addr_kind),
		.signal_dbm        (signal_dbm),
		.service_seen      (service_seen),
		.now_ticks         (now_ticks),
		.link_idle         (link_idle),
		.data_pending      (data_pending),
		.link_signal_valid (link_signal_valid),
		.link_signal_dbm   (link_signal_dbm),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.action            (action),
		.slot              (slot),
		.chosen_addr       (chosen_addr),
		.chosen_addr_kind  (chosen_addr_kind),
		.best_dbm          (best_dbm),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

endmodule
